/* rtl/ppdm_pkg.sv */
package ppdm_pkg;

    // default frame geometry
    localparam int MATRIX_WIDTH_DEFAULT  = 16;
    localparam int MATRIX_HEIGHT_DEFAULT = 16;

    // apb geometry: eight 32-bit registers at 4*i
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_W  = 3;

    localparam int PALETTE_DEPTH = 5;
    localparam int INDEX_W       = 3;
    localparam int CHAN_W        = 8;
    localparam int COLOR_W       = 24;
    localparam int LED_W         = 8;
    localparam int LAYOUT_W      = 2;

    // register map
    localparam logic [REG_SEL_W-1:0] REG_LAYOUT_MODE = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_PALETTE_0   = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_PALETTE_1   = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_PALETTE_2   = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_PALETTE_3   = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_PALETTE_4   = 3'd5;
    localparam logic [REG_SEL_W-1:0] REG_DIM_SCALE   = 3'd6;
    localparam logic [REG_SEL_W-1:0] REG_DIM_OFFSET  = 3'd7;

    // layout codes
    localparam logic [LAYOUT_W-1:0] LAYOUT_COLUMN     = 2'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_SERPENTINE = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_MIRRORED   = 2'd2;

    // palette reset contents
    localparam logic [COLOR_W-1:0] PALETTE_RST_0 = 24'h000000;
    localparam logic [COLOR_W-1:0] PALETTE_RST_1 = 24'hC0C0C0;
    localparam logic [COLOR_W-1:0] PALETTE_RST_2 = 24'hFF0000;
    localparam logic [COLOR_W-1:0] PALETTE_RST_3 = 24'h00FF00;
    localparam logic [COLOR_W-1:0] PALETTE_RST_4 = 24'hFF8080;

    // scale by (256 - scale) / 256, floor, then saturating subtract of offset
    function automatic logic [CHAN_W-1:0] dim_channel(
        input logic [CHAN_W-1:0] chan,
        input logic [CHAN_W-1:0] scale,
        input logic [CHAN_W-1:0] offset
    );
        logic [16:0]       prod;
        logic [CHAN_W-1:0] v;
        prod = {9'd0, chan} * (17'd256 - {9'd0, scale});
        v    = prod[15:8];
        return (v > offset) ? (v - offset) : '0;
    endfunction

endpackage

/* rtl/palette_pixel_dimmer_mapper_unit.sv */
// palette pixel dimmer and led chain mapper
//
// pixel channel: one 3-bit palette index per word, raster order, accepted
// when pix_valid is high and pix_stall low. led channel: chain position,
// dimmed red/green/blue and a last-of-frame flag, taken when led_valid is
// high and led_stall low.
// an accepted word passes an input register, then the result register,
// before led_valid rises. throughput: one word per clock while led_stall
// is low; each word takes one palette lookup, three channel dim
// multipliers and a position adder.
// when the receiver stalls, the result register holds its word and the
// input register can still take one more word; pix_stall rises only while
// both are full and led_stall is high.
// configuration: apb port, register i at byte address 4*i, pready tied
// high; the user writes only while the datapath is empty (unenforced).
// reset: pipeline empties, column/row counters go to the first pixel,
// registers return to their reset values (default palette, no dimming,
// column-major layout).
module palette_pixel_dimmer_mapper_unit #(
    parameter int MATRIX_WIDTH  = ppdm_pkg::MATRIX_WIDTH_DEFAULT,
    parameter int MATRIX_HEIGHT = ppdm_pkg::MATRIX_HEIGHT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppdm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ppdm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ppdm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // pixel input
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  logic [ppdm_pkg::INDEX_W-1:0]      palette_index,
    // led output
    output logic                              led_valid,
    input  logic                              led_stall,
    output logic [ppdm_pkg::LED_W-1:0]        led_index,
    output logic [ppdm_pkg::CHAN_W-1:0]       red,
    output logic [ppdm_pkg::CHAN_W-1:0]       green,
    output logic [ppdm_pkg::CHAN_W-1:0]       blue,
    output logic                              frame_last
);

    localparam int COL_W = (MATRIX_WIDTH  > 1) ? $clog2(MATRIX_WIDTH)  : 1;
    localparam int ROW_W = (MATRIX_HEIGHT > 1) ? $clog2(MATRIX_HEIGHT) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MATRIX_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MATRIX_HEIGHT - 1);
    // chain position is kept modulo 256
    localparam logic [ppdm_pkg::LED_W-1:0] WIDTH_M1  = ppdm_pkg::LED_W'(MATRIX_WIDTH - 1);
    localparam logic [ppdm_pkg::LED_W-1:0] HEIGHT_8  = ppdm_pkg::LED_W'(MATRIX_HEIGHT);
    localparam logic [ppdm_pkg::LED_W-1:0] HEIGHT_M1 = ppdm_pkg::LED_W'(MATRIX_HEIGHT - 1);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [ppdm_pkg::LAYOUT_W-1:0] layout_reg;
    logic [ppdm_pkg::COLOR_W-1:0]  palette_reg [ppdm_pkg::PALETTE_DEPTH];
    logic [ppdm_pkg::CHAN_W-1:0]   scale_reg;
    logic [ppdm_pkg::CHAN_W-1:0]   offset_reg;

    logic                           cfg_write;
    logic [ppdm_pkg::REG_SEL_W-1:0] reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[ppdm_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg     <= ppdm_pkg::LAYOUT_COLUMN;
            palette_reg[0] <= ppdm_pkg::PALETTE_RST_0;
            palette_reg[1] <= ppdm_pkg::PALETTE_RST_1;
            palette_reg[2] <= ppdm_pkg::PALETTE_RST_2;
            palette_reg[3] <= ppdm_pkg::PALETTE_RST_3;
            palette_reg[4] <= ppdm_pkg::PALETTE_RST_4;
            scale_reg      <= '0;
            offset_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                ppdm_pkg::REG_LAYOUT_MODE: layout_reg <= pwdata[ppdm_pkg::LAYOUT_W-1:0];
                ppdm_pkg::REG_PALETTE_0:   palette_reg[0] <= pwdata[ppdm_pkg::COLOR_W-1:0];
                ppdm_pkg::REG_PALETTE_1:   palette_reg[1] <= pwdata[ppdm_pkg::COLOR_W-1:0];
                ppdm_pkg::REG_PALETTE_2:   palette_reg[2] <= pwdata[ppdm_pkg::COLOR_W-1:0];
                ppdm_pkg::REG_PALETTE_3:   palette_reg[3] <= pwdata[ppdm_pkg::COLOR_W-1:0];
                ppdm_pkg::REG_PALETTE_4:   palette_reg[4] <= pwdata[ppdm_pkg::COLOR_W-1:0];
                ppdm_pkg::REG_DIM_SCALE:   scale_reg  <= pwdata[ppdm_pkg::CHAN_W-1:0];
                ppdm_pkg::REG_DIM_OFFSET:  offset_reg <= pwdata[ppdm_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_sel)
            ppdm_pkg::REG_LAYOUT_MODE: prdata = ppdm_pkg::APB_DATA_W'(layout_reg);
            ppdm_pkg::REG_PALETTE_0:   prdata = ppdm_pkg::APB_DATA_W'(palette_reg[0]);
            ppdm_pkg::REG_PALETTE_1:   prdata = ppdm_pkg::APB_DATA_W'(palette_reg[1]);
            ppdm_pkg::REG_PALETTE_2:   prdata = ppdm_pkg::APB_DATA_W'(palette_reg[2]);
            ppdm_pkg::REG_PALETTE_3:   prdata = ppdm_pkg::APB_DATA_W'(palette_reg[3]);
            ppdm_pkg::REG_PALETTE_4:   prdata = ppdm_pkg::APB_DATA_W'(palette_reg[4]);
            ppdm_pkg::REG_DIM_SCALE:   prdata = ppdm_pkg::APB_DATA_W'(scale_reg);
            ppdm_pkg::REG_DIM_OFFSET:  prdata = ppdm_pkg::APB_DATA_W'(offset_reg);
            default:                   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: input register feeds the result register
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic led_valid_reg;
    logic led_valid_next;
    logic pix_take;
    logic led_load;

    // result register loads when empty or being drained
    assign led_load  = !led_valid_reg || !led_stall;
    assign pix_stall = s1_valid_reg && !led_load;
    assign pix_take  = pix_valid && !pix_stall;

    always_comb
    begin
        led_valid_next = led_load ? s1_valid_reg : led_valid_reg;
        s1_valid_next  = pix_take ? 1'b1 : (led_load ? 1'b0 : s1_valid_reg);
    end

    // ---------------------------------------------------------------
    // raster position counters, advanced on each accepted pixel
    // ---------------------------------------------------------------
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             last_col;
    logic             last_row;

    assign last_col = (col_reg == COL_LAST);
    assign last_row = (row_reg == ROW_LAST);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_take)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            led_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            led_valid_reg <= led_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // input register: index plus the pixel's position
    // ---------------------------------------------------------------
    logic [ppdm_pkg::INDEX_W-1:0] s1_index_reg;
    logic [COL_W-1:0]             s1_col_reg;
    logic [ROW_W-1:0]             s1_row_reg;
    logic                         s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            s1_index_reg <= palette_index;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_last_reg  <= last_col && last_row;
        end
    end

    // ---------------------------------------------------------------
    // datapath between the two registers
    // ---------------------------------------------------------------
    logic [ppdm_pkg::COLOR_W-1:0] color;
    logic [ppdm_pkg::CHAN_W-1:0]  red_next;
    logic [ppdm_pkg::CHAN_W-1:0]  green_next;
    logic [ppdm_pkg::CHAN_W-1:0]  blue_next;
    logic [ppdm_pkg::CHAN_W-1:0]  green_dim;
    logic [ppdm_pkg::CHAN_W-1:0]  blue_dim;
    logic [ppdm_pkg::LED_W-1:0]   col_8;
    logic [ppdm_pkg::LED_W-1:0]   row_8;
    logic [ppdm_pkg::LED_W-1:0]   mirror_col;
    logic [ppdm_pkg::LED_W-1:0]   led_index_next;

    // indexes past the last entry fall back to entry 0
    always_comb
    begin
        unique case (s1_index_reg)
            3'd1:    color = palette_reg[1];
            3'd2:    color = palette_reg[2];
            3'd3:    color = palette_reg[3];
            3'd4:    color = palette_reg[4];
            default: color = palette_reg[0];
        endcase
    end

    assign red_next  = ppdm_pkg::dim_channel(color[23:16], scale_reg, offset_reg);
    assign green_dim = ppdm_pkg::dim_channel(color[15:8],  scale_reg, offset_reg);
    assign blue_dim  = ppdm_pkg::dim_channel(color[7:0],   scale_reg, offset_reg);

    // mirrored layout also halves green and blue
    assign green_next = (layout_reg == ppdm_pkg::LAYOUT_MIRRORED) ? (green_dim >> 1) : green_dim;
    assign blue_next  = (layout_reg == ppdm_pkg::LAYOUT_MIRRORED) ? (blue_dim >> 1)  : blue_dim;

    assign col_8      = ppdm_pkg::LED_W'(s1_col_reg);
    assign row_8      = ppdm_pkg::LED_W'(s1_row_reg);
    assign mirror_col = WIDTH_M1 - col_8;

    // chain position, wrapping at 256
    always_comb
    begin
        unique case (layout_reg)
            ppdm_pkg::LAYOUT_SERPENTINE:
            begin
                if (s1_col_reg[0])
                    led_index_next = row_8 + col_8 * HEIGHT_8;
                else
                    led_index_next = (HEIGHT_M1 - row_8) + col_8 * HEIGHT_8;
            end
            ppdm_pkg::LAYOUT_MIRRORED:
            begin
                if (s1_col_reg[0])
                    led_index_next = (HEIGHT_M1 - row_8) + mirror_col * HEIGHT_8;
                else
                    led_index_next = row_8 + mirror_col * HEIGHT_8;
            end
            // column-major, also for the unused code
            default: led_index_next = row_8 + col_8 * HEIGHT_8;
        endcase
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic [ppdm_pkg::LED_W-1:0]  led_index_reg;
    logic [ppdm_pkg::CHAN_W-1:0] red_reg;
    logic [ppdm_pkg::CHAN_W-1:0] green_reg;
    logic [ppdm_pkg::CHAN_W-1:0] blue_reg;
    logic                        frame_last_reg;

    always_ff @(posedge clk)
    begin
        if (led_load && s1_valid_reg)
        begin
            led_index_reg  <= led_index_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            blue_reg       <= blue_next;
            frame_last_reg <= s1_last_reg;
        end
    end

    assign led_valid  = led_valid_reg;
    assign led_index  = led_index_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign frame_last = frame_last_reg;

endmodule

/* rtl/ppdm_checker.sv */
module ppdm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [ppdm_pkg::APB_ADDR_W-1:0]   paddr,
    input logic [ppdm_pkg::APB_DATA_W-1:0]   pwdata,
    input logic                              pready,
    input logic                              pix_valid,
    input logic                              pix_stall,
    input logic                              led_valid,
    input logic                              led_stall,
    input logic [ppdm_pkg::LED_W-1:0]        led_index,
    input logic [ppdm_pkg::CHAN_W-1:0]       red,
    input logic [ppdm_pkg::CHAN_W-1:0]       green,
    input logic [ppdm_pkg::CHAN_W-1:0]       blue,
    input logic                              frame_last
);

    logic [ppdm_pkg::LAYOUT_W-1:0] layout_reg;
    logic [1:0]                    pending_reg;
    logic [1:0]                    pending_next;
    logic                          pix_take;
    logic                          led_take;

    assign pix_take = pix_valid && !pix_stall;
    assign led_take = led_valid && !led_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (pix_take && !led_take)
            pending_next = pending_reg + 2'd1;
        else if (!pix_take && led_take)
            pending_next = pending_reg - 2'd1;
    end

    // shadow of the layout register and count of words in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg  <= ppdm_pkg::LAYOUT_COLUMN;
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (psel && penable && pwrite && pready &&
                paddr[ppdm_pkg::APB_ADDR_W-1:2] == ppdm_pkg::REG_LAYOUT_MODE)
                layout_reg <= pwdata[ppdm_pkg::LAYOUT_W-1:0];
        end
    end

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        led_valid && led_stall |=> led_valid && $stable(led_index) && $stable(red)
            && $stable(green) && $stable(blue) && $stable(frame_last))
        else $error("stalled led word changed");

    // input backs up only behind a stalled, full output
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> led_valid && led_stall)
        else $error("pixel input stalled without output backpressure");

    // at most two words in flight, and output valid only with at least one pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg <= 2'd2) && (!led_valid || pending_reg != 2'd0))
        else $error("word count in flight out of range");

    // mirrored layout halves green and blue: their top bits must be clear
    assert property (@(posedge clk) disable iff (!rst_n)
        led_valid && layout_reg == ppdm_pkg::LAYOUT_MIRRORED |-> !green[7] && !blue[7])
        else $error("green or blue not halved in mirrored layout");

endmodule

bind palette_pixel_dimmer_mapper_unit ppdm_checker u_ppdm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .led_valid  (led_valid),
    .led_stall  (led_stall),
    .led_index  (led_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .frame_last (frame_last)
);
